FILE: rtl/kfs_pkg.sv
`default_nettype none

package kfs_pkg;

  // Field and state widths
  localparam int unsigned FRAME_BITS = 12;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TV_W       = 24;
  localparam int unsigned FPS_W      = 8;
  localparam int unsigned POS_W      = FRAME_BITS + FRAC_BITS;
  localparam int unsigned LERP_W     = 17;
  localparam int unsigned SLOT_W     = FRAME_BITS + 1;

  // Product of time and rate, then rescaled to FRAC_BITS fraction bits
  localparam int unsigned MUL_W   = TV_W + FPS_W + 1;
  localparam int unsigned SHL     = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned SHR     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int unsigned MOVED_W = MUL_W + SHL;
  localparam int unsigned SUM_W   = MOVED_W + 1;
  localparam int unsigned REM_W   = POS_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = (FRAME_BITS > FPS_W) ? FRAME_BITS : FPS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FPS         = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP        = CFG_IDX_W'(2);

  localparam logic [FRAME_BITS-1:0] FC_RESET  = FRAME_BITS'(1);
  localparam logic [FPS_W-1:0]      FPS_RESET = FPS_W'(30);

  // Item kinds
  localparam logic FN_TICK  = 1'b0;
  localparam logic FN_START = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY = '1;
  localparam logic [LERP_W-1:0] ONE_Q16    = LERP_W'(65536);

  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] frame;
    logic                  slot;
  } req_t;

  localparam int unsigned OUT_RAW_W = 2 * (FRAME_BITS + 2) + 1 + LERP_W + 2 + POS_W;
  localparam int unsigned OUT_W     = 8 * ((OUT_RAW_W + 7) / 8);

  // Result item, last member in the lowest bits
  typedef struct packed {
    logic [OUT_W-OUT_RAW_W-1:0] pad;
    logic [POS_W-1:0]           frame_position;
    logic                       running;
    logic                       done_flag;
    logic [LERP_W-1:0]          blend_weight;
    logic                       newer_slot;
    logic                       second_request_slot;
    logic [FRAME_BITS-1:0]      second_request_frame;
    logic                       second_request_valid;
    logic                       first_request_slot;
    logic [FRAME_BITS-1:0]      first_request_frame;
    logic                       first_request_valid;
  } out_item_t;

  // Q.16 frames to FRAC_BITS fraction bits, floor on the way down
  function automatic logic signed [MOVED_W-1:0] rescale(input logic signed [MUL_W-1:0] v);
    logic signed [MOVED_W-1:0] w;
    w = MOVED_W'(v);
    if (FRAC_BITS >= 16) begin
      rescale = w <<< SHL;
    end else begin
      rescale = w >>> SHR;
    end
  endfunction

  // Position fraction to Q1.16 weight
  function automatic logic [LERP_W-1:0] frac_to_lerp(input logic [FRAC_BITS-1:0] f);
    logic [LERP_W+FRAC_BITS-1:0] w;
    w = (LERP_W + FRAC_BITS)'(f);
    if (FRAC_BITS >= 16) begin
      w = w >> SHL;
    end else begin
      w = w << SHR;
    end
    frac_to_lerp = w[LERP_W-1:0];
  endfunction

  // Fold a frame past the end back into the clip, or saturate it
  function automatic logic [FRAME_BITS-1:0] limit_frame(input logic [SLOT_W-1:0] f,
                                                        input logic [FRAME_BITS-1:0] fc,
                                                        input logic lp);
    logic [SLOT_W-1:0] g;
    logic [SLOT_W-1:0] n;
    g = f;
    n = {1'b0, fc};
    if (g >= n) begin
      if (lp) begin
        g = g - n;
      end
      if (g >= n) begin
        g = n - SLOT_W'(1);
      end
    end
    limit_frame = g[FRAME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/keyframe_sampler_two_slot_unit.sv
`default_nettype none

// Channel   | Dir | Signals                         | Contents
// s_axis    | in  | tvalid/tready, tdata[23:0], tuser[0] | tdata: time_value; tuser: func
// m_axis    | out | tvalid/tready, tdata[79:0]      | see m_axis_tdata_o below
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i | 0 clip length, 1 fps, 2 loop_enable
//
// A result is on m_axis once its item has passed the shift-add multiply, one step per
// bit of the rate register, then the sum, range, two resolve and output states. A wrap
// adds the bit-serial remainder (34 steps, one per bit of the position sum) and one
// fix-up. An idle or finished tick skips from the sum to the output, an empty clip from
// the first resolve state. One item is in work at a time; the next accept comes the
// cycle after a result is loaded, and a result still waiting on m_axis holds the next
// item in its last state. Reset is immediate, with no clearing pass.

module keyframe_sampler_two_slot_unit
  import kfs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [TV_W-1:0]       s_axis_tdata_i,   // [23:0] time_value
  input  wire logic [0:0]            s_axis_tuser_i,   // [0] func
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [0] first_request_valid, [12:1] first_request_frame, [13] first_request_slot,
  // [14] second_request_valid, [26:15] second_request_frame, [27] second_request_slot,
  // [28] newer_slot, [45:29] blend_weight, [46] done_flag, [47] running,
  // [75:48] frame_position, [79:76] zero
  output logic [OUT_W-1:0]           m_axis_tdata_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(SUM_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RANGE,
    ST_MOD,
    ST_FIX,
    ST_RES1,
    ST_RES2,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  logic [FRAME_BITS-1:0] fc_q, fc_d;
  logic [FPS_W-1:0]      fps_q, fps_d;
  logic                  loop_q, loop_d;

  logic                     func_q, func_d;
  logic signed [TV_W-1:0]   tv_q, tv_d;
  logic signed [MUL_W-1:0]  mcand_q, mcand_d;
  logic [FPS_W-1:0]         mplier_q, mplier_d;
  logic signed [MUL_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  p_q, p_d;
  logic                     neg_q, neg_d;
  logic [SUM_W-1:0]         mag_q, mag_d;
  logic [REM_W-1:0]         rem_q, rem_d;

  logic                  active_q, active_d;
  logic                  finished_q, finished_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [SLOT_W-1:0]     slot_q [2];
  logic [SLOT_W-1:0]     slot_d [2];
  logic                  newer_q, newer_d;
  logic [LERP_W-1:0]     blend_q, blend_d;
  logic [FRAME_BITS-1:0] prev_q, prev_d;
  logic [FRAME_BITS-1:0] next_q, next_d;
  logic [LERP_W-1:0]     lerp_q, lerp_d;
  req_t                  req_q [2];
  req_t                  req_d [2];

  logic      m_valid_q, m_valid_d;
  out_item_t m_data_q, m_data_d;

  // Combinational helpers
  logic signed [MOVED_W-1:0] moved_c;
  logic [POS_W-1:0]          len_c;
  logic signed [SUM_W-1:0]   len_s_c;
  logic                      below_c, over_c, past_c;
  logic [POS_W-1:0]          clamp_c;
  logic [REM_W-1:0]          trial_c;
  logic [SLOT_W-1:0]         ipart_c;
  logic [FRAC_BITS-1:0]      frac_c;
  logic [FRAME_BITS-1:0]     prev_c, next_c;
  logic                      sp0_c, sp1_c, sn0_c, sn1_c;
  logic                      sp_hit_c, sn_hit_c, sp_idx_c, sn_idx_c;
  logic                      nw_c;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Shared decode of the position and the clip length
  always_comb begin
    moved_c = rescale(acc_q);
    len_c   = {fc_q, {FRAC_BITS{1'b0}}};
    len_s_c = $signed(SUM_W'(len_c));
    below_c = p_q[SUM_W-1];
    over_c  = (p_q >= len_s_c);
    past_c  = (p_q > len_s_c);
    if (below_c) begin
      clamp_c = '0;
    end else if (past_c) begin
      clamp_c = len_c;
    end else begin
      clamp_c = p_q[POS_W-1:0];
    end
    trial_c = {rem_q[POS_W-1:0], mag_q[SUM_W-1]};
    ipart_c = {1'b0, pos_q[POS_W-1:FRAC_BITS]};
    frac_c  = pos_q[FRAC_BITS-1:0];
    prev_c  = limit_frame(ipart_c, fc_q, loop_q);
    next_c  = limit_frame(ipart_c + SLOT_W'(frac_c != '0), fc_q, loop_q);
    sp0_c   = (slot_q[0] == {1'b0, prev_q});
    sp1_c   = (slot_q[1] == {1'b0, prev_q});
    sn0_c   = (slot_q[0] == {1'b0, next_q});
    sn1_c   = (slot_q[1] == {1'b0, next_q});
    sp_hit_c = sp0_c | sp1_c;
    sn_hit_c = sn0_c | sn1_c;
    sp_idx_c = !sp0_c;
    sn_idx_c = !sn0_c;
  end

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    fc_d       = fc_q;
    fps_d      = fps_q;
    loop_d     = loop_q;
    func_d     = func_q;
    tv_d       = tv_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    rem_d      = rem_q;
    active_d   = active_q;
    finished_d = finished_q;
    pos_d      = pos_q;
    slot_d     = slot_q;
    newer_d    = newer_q;
    blend_d    = blend_q;
    prev_d     = prev_q;
    next_d     = next_q;
    lerp_d     = lerp_q;
    req_d      = req_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    nw_c       = 1'b0;

    // Configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_COUNT: fc_d   = cfg_data_i[FRAME_BITS-1:0];
        CFG_FPS:         fps_d  = cfg_data_i[FPS_W-1:0];
        CFG_LOOP:        loop_d = cfg_data_i[0];
        default: ;
      endcase
    end

    // Drop the result once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          func_d   = s_axis_tuser_i[0];
          tv_d     = $signed(s_axis_tdata_i);
          mcand_d  = MUL_W'($signed(s_axis_tdata_i));
          mplier_d = fps_q;
          acc_d    = '0;
          cnt_d    = '0;
          req_d[0] = '0;
          req_d[1] = '0;
          state_d  = ST_MUL;
        end
      end

      // Shift-add multiply, one rate bit per cycle
      ST_MUL: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FPS_W - 1)) begin
          state_d = ST_SUM;
        end
      end

      // Form the new position
      ST_SUM: begin
        if (func_q == FN_START) begin
          p_d        = SUM_W'(moved_c);
          active_d   = 1'b1;
          finished_d = 1'b0;
          slot_d[0]  = SLOT_EMPTY;
          slot_d[1]  = SLOT_EMPTY;
          blend_d    = ONE_Q16;
          state_d    = ST_RANGE;
        end else if (!active_q) begin
          state_d = ST_OUT;
        end else if (finished_q) begin
          active_d = 1'b0;
          state_d  = ST_OUT;
        end else begin
          p_d     = SUM_W'($signed({1'b0, pos_q})) + SUM_W'(moved_c);
          state_d = ST_RANGE;
        end
      end

      // Wrap, clamp or keep
      ST_RANGE: begin
        state_d = ST_RES1;
        if (loop_q) begin
          if (below_c || over_c) begin
            neg_d   = below_c;
            mag_d   = below_c ? $unsigned(-p_q) : $unsigned(p_q);
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_MOD;
          end else begin
            pos_d = p_q[POS_W-1:0];
          end
        end else if (func_q == FN_START) begin
          pos_d = clamp_c;
        end else if ((over_c && !tv_q[TV_W-1] && (tv_q != '0)) ||
                     (below_c && tv_q[TV_W-1])) begin
          pos_d      = clamp_c;
          finished_d = 1'b1;
        end else begin
          pos_d = p_q[POS_W-1:0];
        end
      end

      // Restoring remainder, one bit of the magnitude per cycle
      ST_MOD: begin
        if (trial_c >= {1'b0, len_c}) begin
          rem_d = trial_c - {1'b0, len_c};
        end else begin
          rem_d = trial_c;
        end
        mag_d = mag_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          state_d = ST_FIX;
        end
      end

      // Make the remainder non-negative
      ST_FIX: begin
        if (neg_q && (rem_q != '0)) begin
          pos_d = len_c - rem_q[POS_W-1:0];
        end else begin
          pos_d = rem_q[POS_W-1:0];
        end
        state_d = ST_RES1;
      end

      // Frames on either side of the position
      ST_RES1: begin
        if (fc_q == '0) begin
          pos_d   = '0;
          blend_d = ONE_Q16;
          state_d = ST_OUT;
        end else begin
          prev_d  = prev_c;
          next_d  = next_c;
          lerp_d  = (prev_c == next_c) ? ONE_Q16 : frac_to_lerp(frac_c);
          state_d = ST_RES2;
        end
      end

      // Look the frames up in the slots and request what is missing
      ST_RES2: begin
        if (!sp_hit_c && !sn_hit_c) begin
          blend_d = lerp_q;
          newer_d = 1'b1;
          if (prev_q != next_q) begin
            slot_d[0] = {1'b0, prev_q};
            slot_d[1] = {1'b0, next_q};
            req_d[0]  = '{valid: 1'b1, frame: prev_q, slot: 1'b0};
            req_d[1]  = '{valid: 1'b1, frame: next_q, slot: 1'b1};
          end else begin
            slot_d[1] = {1'b0, next_q};
            req_d[0]  = '{valid: 1'b1, frame: next_q, slot: 1'b1};
          end
        end else if (!sn_hit_c) begin
          nw_c         = !sp_idx_c;
          blend_d      = lerp_q;
          newer_d      = nw_c;
          slot_d[nw_c] = {1'b0, next_q};
          req_d[0]     = '{valid: 1'b1, frame: next_q, slot: nw_c};
        end else if (!sp_hit_c) begin
          nw_c         = !sn_idx_c;
          blend_d      = ONE_Q16 - lerp_q;
          newer_d      = nw_c;
          slot_d[nw_c] = {1'b0, prev_q};
          req_d[0]     = '{valid: 1'b1, frame: prev_q, slot: nw_c};
        end else if (sp_idx_c == sn_idx_c) begin
          blend_d = ONE_Q16;
          newer_d = sn_idx_c;
        end else begin
          blend_d = (sn_idx_c == newer_q) ? lerp_q : ONE_Q16 - lerp_q;
        end
        state_d = ST_OUT;
      end

      // Load the output register when it is free
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d                     = 1'b1;
          m_data_d.pad                  = '0;
          m_data_d.frame_position       = pos_q;
          m_data_d.running              = active_q;
          m_data_d.done_flag            = finished_q;
          m_data_d.blend_weight         = blend_q;
          m_data_d.newer_slot           = newer_q;
          m_data_d.second_request_slot  = req_q[1].slot;
          m_data_d.second_request_frame = req_q[1].frame;
          m_data_d.second_request_valid = req_q[1].valid;
          m_data_d.first_request_slot   = req_q[0].slot;
          m_data_d.first_request_frame  = req_q[0].frame;
          m_data_d.first_request_valid  = req_q[0].valid;
          state_d                       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fc_q       <= FC_RESET;
      fps_q      <= FPS_RESET;
      loop_q     <= 1'b0;
      func_q     <= FN_TICK;
      tv_q       <= '0;
      mcand_q    <= '0;
      mplier_q   <= '0;
      acc_q      <= '0;
      cnt_q      <= '0;
      p_q        <= '0;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      rem_q      <= '0;
      active_q   <= 1'b0;
      finished_q <= 1'b0;
      pos_q      <= '0;
      slot_q[0]  <= SLOT_EMPTY;
      slot_q[1]  <= SLOT_EMPTY;
      newer_q    <= 1'b0;
      blend_q    <= '0;
      prev_q     <= '0;
      next_q     <= '0;
      lerp_q     <= '0;
      req_q[0]   <= '0;
      req_q[1]   <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      fc_q       <= fc_d;
      fps_q      <= fps_d;
      loop_q     <= loop_d;
      func_q     <= func_d;
      tv_q       <= tv_d;
      mcand_q    <= mcand_d;
      mplier_q   <= mplier_d;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      p_q        <= p_d;
      neg_q      <= neg_d;
      mag_q      <= mag_d;
      rem_q      <= rem_d;
      active_q   <= active_d;
      finished_q <= finished_d;
      pos_q      <= pos_d;
      slot_q     <= slot_d;
      newer_q    <= newer_d;
      blend_q    <= blend_d;
      prev_q     <= prev_d;
      next_q     <= next_d;
      lerp_q     <= lerp_d;
      req_q      <= req_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
    end
  end

  // Two requests in one item go to different slots
  a_req_slots_differ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q.first_request_valid && m_data_q.second_request_valid
    |-> m_data_q.first_request_slot != m_data_q.second_request_slot)
    else $error("both requests target one slot");

  // A second request never comes without a first
  a_req_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q.second_request_valid |-> m_data_q.first_request_valid)
    else $error("second request without first");

  // The slots never hold the same frame
  a_slots_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q[0] != slot_q[1]) || (slot_q[0] == SLOT_EMPTY))
    else $error("both slots hold one frame");

endmodule

`default_nettype wire
